### hw/rtl/srvm_pkg.sv
// shared constants and types for the sixteen-register vm core
// no dependencies
package srvm_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int MEM_BYTES   = 4096;
    localparam int SCREEN_ROWS = 32;
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);
    localparam int SI_W        = $clog2(STACK_DEPTH);
    localparam int ROW_W       = $clog2(SCREEN_ROWS);
    localparam int MA_W        = $clog2(MEM_BYTES);

    localparam logic [1:0] FN_LOAD = 2'd0;
    localparam logic [1:0] FN_EXEC = 2'd1;
    localparam logic [1:0] FN_TICK = 2'd2;
    localparam logic [1:0] FN_ROW  = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_UNKNOWN   = 2'd1;
    localparam logic [1:0] ST_OVERFLOW  = 2'd2;
    localparam logic [1:0] ST_UNDERFLOW = 2'd3;

    // memory port request from the sequencer
    typedef struct packed {
        logic        rd;
        logic        wr;
        logic [11:0] addr;
        logic [7:0]  wdata;
    } t_mem_req;

endpackage

### hw/rtl/srvm_mem.sv
// 4 KiB byte memory, one port, registered read
// depends on srvm_pkg
module srvm_mem (
    input  logic               i_clk,
    input  srvm_pkg::t_mem_req i_req,
    output logic [7:0]         o_rdata
);
    logic [7:0] r_mem [srvm_pkg::MEM_BYTES];

    always_ff @(posedge i_clk) begin
        if (i_req.wr) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        if (i_req.rd) begin
            o_rdata <= r_mem[i_req.addr];
        end
    end
endmodule

### hw/rtl/sixteen_register_vm_core.sv
// sixteen-register vm core: one word in, one word out per item
// each item ends in S_DONE; load and tick go there directly, row read via S_ROWRD; execute
//   fetches in S_F0-S_F2 and decodes in S_DEC, then reads and writes each sprite row, moves
//   V0..Vx to or from memory on Fx65/Fx55, writes three digits on Fx33, or clears the screen in S_CLS
// throughput: one item at a time, next word taken the cycle after the result is accepted
// reset: synchronous active low; registers zero, pc 0x200, screen cleared by valid bits
module sixteen_register_vm_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // func[1:0], address[13:2], write_byte[21:14], keys[37:22], random_byte[45:38]
    input  logic [47:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // pc_now[11:0], flag_value[19:12], sound_on[20], delay_now[28:21],
    // row_bits[92:29], status[94:93]
    output logic [95:0] m_axis_tdata
);
    localparam logic [3:0] S_IDLE = 4'd0, S_F0 = 4'd1, S_F1 = 4'd2, S_F2 = 4'd3,
        S_DEC = 4'd4, S_DRAW_RD = 4'd5, S_DRAW_WR = 4'd6, S_BLK = 4'd7,
        S_BLK_RD = 4'd8, S_CLS = 4'd9, S_DONE = 4'd10, S_ROWRD = 4'd11;

    logic [3:0]  r_state;
    logic [11:0] r_addr;
    logic [7:0]  r_rnd;
    logic [15:0] r_keys;
    logic [7:0]  r_v [16];
    logic [15:0] r_i;
    logic [11:0] r_pc;
    logic [srvm_pkg::SP_W-1:0] r_sp;
    logic [11:0] r_stk [srvm_pkg::STACK_DEPTH];
    logic [7:0]  r_dt, r_st;
    logic [63:0] r_fb [srvm_pkg::SCREEN_ROWS];
    logic [srvm_pkg::SCREEN_ROWS-1:0] r_fbv;
    logic [15:0] r_op;
    logic [4:0]  r_cnt;
    logic        r_erased;
    logic [1:0]  r_status;
    logic [63:0] r_row;
    logic        r_ovalid;
    logic [95:0] r_odata;

    srvm_pkg::t_mem_req mreq;
    logic [7:0] mrdata;

    srvm_mem u_mem (.i_clk(i_clk), .i_req(mreq), .o_rdata(mrdata));

    logic [3:0] ox, oy, on;
    logic [7:0] okk;
    assign ox  = r_op[11:8];
    assign oy  = r_op[7:4];
    assign on  = r_op[3:0];
    assign okk = r_op[7:0];

    logic [srvm_pkg::ROW_W-1:0] draw_y;
    logic [5:0]  draw_x;
    logic [63:0] spr_mask, cur_row;
    logic [11:0] i_plus;
    logic [7:0]  bcd_h, bcd_t, bcd_o;
    logic [7:0]  vx_r;

    assign vx_r   = r_v[ox];
    assign draw_y = srvm_pkg::ROW_W'(r_v[oy] + 8'(r_cnt));
    assign draw_x = r_v[ox][5:0];
    assign i_plus = r_i[11:0] + 12'(r_cnt);
    assign cur_row = r_fbv[draw_y] ? r_fb[draw_y] : 64'd0;
    // rotate sprite byte into place, wrapping at the right edge
    always_comb begin
        logic [127:0] wide;
        wide = {mrdata, 56'd0, mrdata, 56'd0} >> draw_x;
        spr_mask = wide[63:0];
    end
    // bcd digits: hundreds by constant compares, tens by multiply-and-shift, ones by subtract
    always_comb begin
        logic [7:0] rem;
        bcd_h = (vx_r >= 8'd200) ? 8'd2 : (vx_r >= 8'd100) ? 8'd1 : 8'd0;
        rem   = vx_r - 8'(bcd_h * 8'd100);
        bcd_t = 8'((16'(rem) * 16'd205) >> 11);
        bcd_o = rem - 8'(bcd_t * 8'd10);
    end

    assign s_axis_tready = (r_state == S_IDLE) && !r_ovalid;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    always_comb begin
        mreq = '0;
        unique case (r_state)
            S_IDLE: begin
                mreq.wr    = s_axis_tvalid && s_axis_tready
                             && s_axis_tdata[1:0] == srvm_pkg::FN_LOAD;
                mreq.addr  = s_axis_tdata[13:2];
                mreq.wdata = s_axis_tdata[21:14];
            end
            S_F0: begin
                mreq.rd = 1'b1;
                mreq.addr = r_pc;
            end
            S_F1: begin
                mreq.rd = 1'b1;
                mreq.addr = r_pc + 12'd1;
            end
            S_DRAW_RD, S_BLK_RD: begin
                mreq.rd = 1'b1;
                mreq.addr = i_plus;
            end
            S_BLK: begin
                mreq.addr = i_plus;
                if (okk == 8'h33) begin
                    mreq.wr = 1'b1;
                    mreq.wdata = (r_cnt == 5'd0) ? bcd_h : (r_cnt == 5'd1) ? bcd_t : bcd_o;
                end else if (okk == 8'h55) begin
                    mreq.wr = 1'b1;
                    mreq.wdata = r_v[r_cnt[3:0]];
                end else begin
                    mreq.rd = 1'b1;
                end
            end
            default: mreq = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            for (int k = 0; k < 16; k++) r_v[k] <= 8'd0;
            r_i      <= 16'd0;
            r_pc     <= 12'h200;
            r_sp     <= '0;
            r_dt     <= 8'd0;
            r_st     <= 8'd0;
            r_fbv    <= '0;
        end else begin
            if (r_ovalid && m_axis_tready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
                    r_addr  <= s_axis_tdata[13:2];
                    r_keys  <= s_axis_tdata[37:22];
                    r_rnd   <= s_axis_tdata[45:38];
                    r_status <= srvm_pkg::ST_OK;
                    r_row   <= 64'd0;
                    r_cnt   <= 5'd0;
                    case (s_axis_tdata[1:0])
                        srvm_pkg::FN_EXEC: r_state <= S_F0;
                        srvm_pkg::FN_ROW:  r_state <= S_ROWRD;
                        srvm_pkg::FN_TICK: begin
                            if (r_dt != 8'd0) r_dt <= r_dt - 8'd1;
                            if (r_st != 8'd0) r_st <= r_st - 8'd1;
                            r_state <= S_DONE;
                        end
                        default: r_state <= S_DONE;
                    endcase
                end
                S_ROWRD: begin
                    if (r_addr < 12'(srvm_pkg::SCREEN_ROWS)
                        && r_fbv[r_addr[srvm_pkg::ROW_W-1:0]])
                        r_row <= r_fb[r_addr[srvm_pkg::ROW_W-1:0]];
                    r_state <= S_DONE;
                end
                S_F0: r_state <= S_F1;
                S_F1: begin
                    r_op[15:8] <= mrdata;
                    r_state <= S_F2;
                end
                S_F2: begin
                    r_op[7:0] <= mrdata;
                    r_state <= S_DEC;
                end
                S_DEC: begin
                    r_pc <= r_pc + 12'd2;
                    r_state <= S_DONE;
                    case (r_op[15:12])
                        4'h0: if (r_op == 16'h00E0) begin
                            r_cnt <= 5'd0;
                            r_state <= S_CLS;
                        end else if (r_op == 16'h00EE) begin
                            if (r_sp == '0) r_status <= srvm_pkg::ST_UNDERFLOW;
                            else begin
                                r_sp <= r_sp - 1'b1;
                                r_pc <= r_stk[srvm_pkg::SI_W'(r_sp - 1'b1)] + 12'd2;
                            end
                        end else r_status <= srvm_pkg::ST_UNKNOWN;
                        4'h1: r_pc <= r_op[11:0];
                        4'h2: if (r_sp >= srvm_pkg::SP_W'(srvm_pkg::STACK_DEPTH))
                            r_status <= srvm_pkg::ST_OVERFLOW;
                        else begin
                            r_stk[r_sp[srvm_pkg::SI_W-1:0]] <= r_pc;
                            r_sp <= r_sp + 1'b1;
                            r_pc <= r_op[11:0];
                        end
                        4'h3: if (vx_r == okk) r_pc <= r_pc + 12'd4;
                        4'h4: if (vx_r != okk) r_pc <= r_pc + 12'd4;
                        4'h5: if (on != 4'd0) r_status <= srvm_pkg::ST_UNKNOWN;
                            else if (vx_r == r_v[oy]) r_pc <= r_pc + 12'd4;
                        4'h6: r_v[ox] <= okk;
                        4'h7: r_v[ox] <= vx_r + okk;
                        4'h8: case (on)
                            4'h0: r_v[ox] <= r_v[oy];
                            4'h1: r_v[ox] <= vx_r | r_v[oy];
                            4'h2: r_v[ox] <= vx_r & r_v[oy];
                            4'h3: r_v[ox] <= vx_r ^ r_v[oy];
                            4'h4: begin
                                r_v[ox] <= vx_r + r_v[oy];
                                r_v[15] <= 8'({1'b0, vx_r} + {1'b0, r_v[oy]} > 9'd255);
                            end
                            4'h5: begin
                                r_v[ox] <= vx_r - r_v[oy];
                                r_v[15] <= 8'(vx_r >= r_v[oy]);
                            end
                            4'h6: begin
                                r_v[ox] <= vx_r >> 1;
                                r_v[15] <= 8'(vx_r[0]);
                            end
                            4'h7: begin
                                r_v[ox] <= r_v[oy] - vx_r;
                                r_v[15] <= 8'(r_v[oy] >= vx_r);
                            end
                            4'hE: begin
                                r_v[ox] <= vx_r << 1;
                                r_v[15] <= 8'(vx_r[7]);
                            end
                            default: r_status <= srvm_pkg::ST_UNKNOWN;
                        endcase
                        4'h9: if (on != 4'd0) r_status <= srvm_pkg::ST_UNKNOWN;
                            else if (vx_r != r_v[oy]) r_pc <= r_pc + 12'd4;
                        4'hA: r_i <= {4'd0, r_op[11:0]};
                        4'hB: r_pc <= r_op[11:0] + 12'(r_v[0]);
                        4'hC: r_v[ox] <= r_rnd & okk;
                        4'hD: begin
                            r_cnt <= 5'd0;
                            r_erased <= 1'b0;
                            r_state <= (on == 4'd0) ? S_DONE : S_DRAW_RD;
                            if (on == 4'd0) r_v[15] <= 8'd0;
                        end
                        4'hE: if (okk == 8'h9E) begin
                            if (r_keys[vx_r[3:0]]) r_pc <= r_pc + 12'd4;
                        end else if (okk == 8'hA1) begin
                            if (!r_keys[vx_r[3:0]]) r_pc <= r_pc + 12'd4;
                        end else r_status <= srvm_pkg::ST_UNKNOWN;
                        default: case (okk)
                            8'h07: r_v[ox] <= r_dt;
                            8'h15: r_dt <= vx_r;
                            8'h18: r_st <= vx_r;
                            8'h1E: r_i <= r_i + 16'(vx_r);
                            8'h29: r_i <= 16'(vx_r[3:0]) * 16'd5;
                            8'h33, 8'h55, 8'h65: begin
                                r_cnt <= 5'd0;
                                r_state <= S_BLK;
                            end
                            default: r_status <= srvm_pkg::ST_UNKNOWN;
                        endcase
                    endcase
                end
                S_DRAW_RD: r_state <= S_DRAW_WR;
                S_DRAW_WR: begin
                    r_fb[draw_y]  <= cur_row ^ spr_mask;
                    r_fbv[draw_y] <= 1'b1;
                    if ((cur_row & spr_mask) != 64'd0) r_erased <= 1'b1;
                    if (r_cnt + 5'd1 == {1'b0, on}) begin
                        r_v[15] <= 8'(r_erased || (cur_row & spr_mask) != 64'd0);
                        r_state <= S_DONE;
                    end else begin
                        r_cnt <= r_cnt + 5'd1;
                        r_state <= S_DRAW_RD;
                    end
                end
                S_BLK: begin
                    if (okk == 8'h65) r_state <= S_BLK_RD;
                    else if ((okk == 8'h33 && r_cnt == 5'd2)
                             || (okk == 8'h55 && r_cnt[3:0] == ox))
                        r_state <= S_DONE;
                    else r_cnt <= r_cnt + 5'd1;
                end
                S_BLK_RD: begin
                    // byte read in S_BLK arrives now
                    r_v[r_cnt[3:0]] <= mrdata;
                    if (r_cnt[3:0] == ox) r_state <= S_DONE;
                    else begin
                        r_cnt <= r_cnt + 5'd1;
                        r_state <= S_BLK;
                    end
                end
                S_CLS: begin
                    r_fbv <= '0;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    r_ovalid <= 1'b1;
                    r_odata  <= {1'b0, r_status, r_row, r_dt, (r_st != 8'd0),
                                 r_v[15], r_pc};
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !s_axis_tready) else $error("accept while busy");
    a_sp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= srvm_pkg::SP_W'(srvm_pkg::STACK_DEPTH)) else $error("stack pointer range");
    a_done_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |=> r_ovalid) else $error("result lost");
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_state != S_IDLE) |-> $past(r_ovalid)) else $error("extra result");
`endif
endmodule
